// ----- src/drepd_pkg.sv -----
// Shared types, constants and tracker arithmetic for the DC-removed envelope peak detector.
package drepd_pkg;

    typedef logic [1:0]  cfg_index_t;
    typedef logic [15:0] q8_t;

    localparam cfg_index_t CFG_DC_SHIFT   = 2'd0;
    localparam cfg_index_t CFG_ENV_SHIFT  = 2'd1;
    localparam cfg_index_t CFG_PEAK_SCALE = 2'd2;

    localparam logic [3:0]  DC_SHIFT_RESET   = 4'd12;
    localparam logic [3:0]  ENV_SHIFT_RESET  = 4'd8;
    localparam logic [15:0] PEAK_SCALE_RESET = 16'd402;
    localparam q8_t         DC_RESET         = 16'd32768;
    localparam q8_t         ENV_RESET        = 16'd0;
    localparam q8_t         Q8_MAX           = 16'd65280;
    localparam logic [32:0] PEAK_ROUND       = 33'd32768;
    localparam int          PEAK_SHIFT       = 16;
    localparam logic [7:0]  PEAK_MAX         = 8'd255;

    // cur + ((target - cur) >>> sh); the arithmetic shift rounds downward steps
    // to the ceiling of their magnitude.
    function automatic q8_t track(input q8_t cur, input q8_t target, input logic [3:0] sh);
        logic signed [16:0] diff;
        logic signed [16:0] step;
        logic        [16:0] sum;
        begin
            diff = $signed({1'b0, target}) - $signed({1'b0, cur});
            step = diff >>> sh;
            sum  = {1'b0, cur} + $unsigned(step);
            return sum[15:0];
        end
    endfunction

endpackage

// ----- src/dc_removed_envelope_peak_detector.sv -----
// Top level: DC tracker, rectified envelope tracker and peak scaling, three-stage pipeline.
//
// One 8-bit sample beat is taken every cycle while in_ready is high. It passes an
// input register, a stage that updates the DC and envelope trackers (the only
// loop), and an output register that holds the scaled, saturated peak beside
// both levels. Each stage advances when the one after it is empty or moving, so
// a waiting result does not stop new samples until all three stages are full.
// Configuration writes take effect at once and are to be made by the user while
// the pipeline is empty; the block itself does not enforce this.
module dc_removed_envelope_peak_detector
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  drepd_pkg::cfg_index_t cfg_index,
    input  logic [15:0]           cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            peak_amplitude,
    output logic [15:0]           envelope_level,
    output logic [15:0]           dc_level
);

    import drepd_pkg::*;

    logic [3:0]  dc_shift_reg;
    logic [3:0]  env_shift_reg;
    logic [15:0] peak_scale_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_sample_reg;
    logic        s2_valid_reg;
    q8_t         s2_dc_reg;
    q8_t         s2_env_reg;
    logic        s3_valid_reg;
    logic [7:0]  s3_peak_reg;
    q8_t         s3_dc_reg;
    q8_t         s3_env_reg;

    q8_t         dc_state_reg;
    q8_t         env_state_reg;
    q8_t         dc_next;
    q8_t         env_next;
    q8_t         scaled;
    q8_t         mag;

    logic        adv1;
    logic        adv2;
    logic        adv3;
    logic        load2;
    logic        load3;

    logic [32:0] product;
    logic [16:0] peak_wide;
    logic [7:0]  peak_next;

    assign adv3     = !s3_valid_reg || out_ready;
    assign load3    = s2_valid_reg && adv3;
    assign adv2     = !s2_valid_reg || adv3;
    assign load2    = s1_valid_reg && adv2;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        scaled   = {s1_sample_reg, 8'd0};
        dc_next  = track(dc_state_reg, scaled, dc_shift_reg);
        mag      = (scaled >= dc_next) ? (scaled - dc_next) : (dc_next - scaled);
        env_next = track(env_state_reg, mag, env_shift_reg);
    end

    always_comb
    begin
        product   = {1'b0, 32'(s2_env_reg) * 32'(peak_scale_reg)} + PEAK_ROUND;
        peak_wide = product[32:PEAK_SHIFT];
        peak_next = (peak_wide > 17'(PEAK_MAX)) ? PEAK_MAX : peak_wide[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_shift_reg   <= DC_SHIFT_RESET;
            env_shift_reg  <= ENV_SHIFT_RESET;
            peak_scale_reg <= PEAK_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DC_SHIFT:   dc_shift_reg   <= cfg_wdata[3:0];
                CFG_ENV_SHIFT:  env_shift_reg  <= cfg_wdata[3:0];
                CFG_PEAK_SCALE: peak_scale_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            dc_state_reg  <= DC_RESET;
            env_state_reg <= ENV_RESET;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
            if (load2)
            begin
                dc_state_reg  <= dc_next;
                env_state_reg <= env_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
            s1_sample_reg <= sample;
        if (load2)
        begin
            s2_dc_reg  <= dc_next;
            s2_env_reg <= env_next;
        end
        if (load3)
        begin
            s3_peak_reg <= peak_next;
            s3_dc_reg   <= s2_dc_reg;
            s3_env_reg  <= s2_env_reg;
        end
    end

    assign out_valid      = s3_valid_reg;
    assign peak_amplitude = s3_peak_reg;
    assign envelope_level = s3_env_reg;
    assign dc_level       = s3_dc_reg;

    // trackers never leave the Q8 range of the scaled sample
    assert property (@(posedge clk) disable iff (!rst_n) dc_state_reg <= Q8_MAX)
        else $error("dc estimate out of range");

    assert property (@(posedge clk) disable iff (!rst_n) env_state_reg <= Q8_MAX)
        else $error("envelope estimate out of range");

    // full pipeline with a stalled result must refuse input
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken with full pipeline");

    // a stage-2 beat moved on lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n) load3 |=> out_valid)
        else $error("beat lost between stage 2 and output");

    // trackers update only when a beat leaves the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !load2 |=> ($stable(dc_state_reg) && $stable(env_state_reg)))
        else $error("tracker state changed without a beat");

endmodule

// ----- bench/dc_removed_envelope_peak_detector_tb.sv -----
// Self-checking testbench for the DC-removed envelope peak detector: random waves, idling, checks.
module dc_removed_envelope_peak_detector_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import drepd_pkg::*;

    localparam cfg_index_t CFG_UNMAPPED = 2'd3;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 128;

    typedef struct packed {
        logic [7:0] peak;
        q8_t        env;
        q8_t        dc;
    } level_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_index = CFG_DC_SHIFT;
    logic [15:0] cfg_wdata = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  sample = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  peak_amplitude;
    logic [15:0] envelope_level;
    logic [15:0] dc_level;

    // predictor state and register copy
    logic [3:0]  dc_shift_cfg = DC_SHIFT_RESET;
    logic [3:0]  env_shift_cfg = ENV_SHIFT_RESET;
    logic [15:0] peak_scale_cfg = PEAK_SCALE_RESET;
    q8_t         dc_est = DC_RESET;
    q8_t         env_est = ENV_RESET;

    logic [7:0]    sample_queue[$];
    level_result_t expected_levels[$];
    int            items_queued = 0;
    int            items_accepted = 0;
    int            error_count = 0;
    int            mismatch_count = 0;
    logic          in_beat = 1'b0;
    int            in_gap = 0;
    int            out_gap = 0;
    bit            in_idle_on = 1'b1;
    bit            out_idle_on = 1'b1;

    dc_removed_envelope_peak_detector dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .peak_amplitude (peak_amplitude),
        .envelope_level (envelope_level),
        .dc_level       (dc_level)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("dc_removed_envelope_peak_detector verification failed");
        $finish;
    end

    // downward steps take the ceiling of the shifted magnitude
    function automatic q8_t follow(input q8_t cur, input q8_t target, input logic [3:0] sh);
        q8_t gap;
        begin
            if (target >= cur)
                return cur + ((target - cur) >> sh);
            gap = cur - target - 16'd1;
            return cur - ((gap >> sh) + 16'd1);
        end
    endfunction

    function automatic level_result_t advance_trackers(input logic [7:0] smp);
        q8_t           scaled;
        q8_t           dev;
        logic [32:0]   prod;
        level_result_t r;
        begin
            scaled = {smp, 8'd0};
            dc_est = follow(dc_est, scaled, dc_shift_cfg);
            dev = (scaled >= dc_est) ? scaled - dc_est : dc_est - scaled;
            env_est = follow(env_est, dev, env_shift_cfg);
            prod = 33'(env_est) * 33'(peak_scale_cfg) + PEAK_ROUND;
            prod = prod >> PEAK_SHIFT;
            r.peak = (prod > 33'(PEAK_MAX)) ? PEAK_MAX : prod[7:0];
            r.env = env_est;
            r.dc = dc_est;
            return r;
        end
    endfunction

    function automatic int idle_len();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                return $urandom_range(1, 2);
            if (r < 93)
                return $urandom_range(3, 6);
            return $urandom_range(10, 40);
        end
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_beat)
        begin
            if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap = in_gap - 1;
            end
            else if (sample_queue.size() != 0)
            begin
                sample <= sample_queue.pop_front();
                in_valid <= 1'b1;
                in_gap = (in_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (out_gap != 0)
        begin
            out_ready <= 1'b0;
            out_gap = out_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_idle_on && $urandom_range(0, 3) == 0)
                out_gap = idle_len();
        end
    end

    // monitor: register copy, prediction and result check
    always @(posedge clk)
    begin
        level_result_t want;
        in_beat <= in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DC_SHIFT:   dc_shift_cfg = cfg_wdata[3:0];
                    CFG_ENV_SHIFT:  env_shift_cfg = cfg_wdata[3:0];
                    CFG_PEAK_SCALE: peak_scale_cfg = cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                expected_levels.push_back(advance_trackers(sample));
                items_accepted = items_accepted + 1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    error_count = error_count + 1;
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: peak %0d env %0d dc %0d",
                                 peak_amplitude, envelope_level, dc_level);
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (peak_amplitude !== want.peak || envelope_level !== want.env
                        || dc_level !== want.dc)
                    begin
                        error_count = error_count + 1;
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch: peak %0d/%0d env %0d/%0d dc %0d/%0d (exp/got)",
                                     want.peak, peak_amplitude, want.env, envelope_level,
                                     want.dc, dc_level);
                    end
                end
            end
        end
    end

    task automatic queue_sample(input logic [7:0] v);
        sample_queue.push_back(v);
        items_queued = items_queued + 1;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // shift registers take the low nibble; upper data bits are junk on purpose
    task automatic set_levels(input logic [3:0] dcs, input logic [3:0] envs,
                              input logic [15:0] scale);
        write_reg(CFG_DC_SHIFT, (16'($urandom()) & 16'hFFF0) | {12'd0, dcs});
        write_reg(CFG_ENV_SHIFT, (16'($urandom()) & 16'hFFF0) | {12'd0, envs});
        write_reg(CFG_PEAK_SCALE, scale);
        end_writes();
    endtask

    task automatic drain_pipeline();
        do
            @(negedge clk);
        while (items_accepted != items_queued || expected_levels.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [3:0] pick_shift();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                return 4'd0;
            if (r == 1)
                return 4'd1;
            if (r == 2)
                return 4'd15;
            return 4'($urandom_range(0, 15));
        end
    endfunction

    function automatic logic [15:0] pick_scale();
        int r;
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                return 16'd0;
            if (r == 1)
                return 16'hFFFF;
            if (r == 2)
                return PEAK_SCALE_RESET;
            if (r == 3)
                return 16'($urandom_range(60000, 65535));
            return 16'($urandom_range(0, 65535));
        end
    endfunction

    // random noise, square, triangle or noisy level
    task automatic queue_wave(input int count);
        int shape;
        int lo;
        int hi;
        int period;
        int pos;
        int v;
        shape = $urandom_range(0, 3);
        lo = $urandom_range(0, 127);
        hi = $urandom_range(128, 255);
        if ($urandom_range(0, 3) == 0)
        begin
            lo = 0;
            hi = 255;
        end
        period = $urandom_range(1, 24);
        for (int k = 0; k < count; k++)
        begin
            pos = k % (2 * period);
            case (shape)
                0: v = $urandom_range(0, 255);
                1: v = (pos < period) ? hi : lo;
                2: v = (pos < period) ? lo + (hi - lo) * pos / period
                                      : hi - (hi - lo) * (pos - period) / period;
                default:
                begin
                    v = lo + $urandom_range(0, 16) - 8;
                    if (v < 0)
                        v = 0;
                end
            endcase
            queue_sample(v[7:0]);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, extremes and mid-scale
        queue_sample(8'd128);
        queue_sample(8'd255);
        queue_sample(8'd0);
        queue_sample(8'd255);
        queue_sample(8'd0);
        queue_sample(8'd1);
        queue_sample(8'd254);
        queue_sample(8'h55);
        queue_sample(8'hAA);
        queue_sample(8'd128);
        drain_pipeline();

        // write to an unmapped index must leave every register alone
        write_reg(CFG_UNMAPPED, 16'h0001);
        end_writes();
        queue_sample(8'd255);
        queue_sample(8'd0);
        queue_sample(8'd200);
        drain_pipeline();

        // zero shifts jump straight to target; full-scale gain saturates the peak
        set_levels(4'd0, 4'd0, 16'hFFFF);
        queue_sample(8'd255);
        queue_sample(8'd0);
        queue_sample(8'd255);
        queue_sample(8'd0);
        queue_sample(8'd200);
        queue_sample(8'd3);
        drain_pipeline();

        set_levels(4'd15, 4'd15, 16'd0);
        queue_sample(8'd0);
        queue_sample(8'd255);
        queue_sample(8'd0);
        queue_sample(8'd255);
        drain_pipeline();

        for (int p = 0; p < PHASES; p++)
        begin
            in_idle_on = (p % 4 == 0) || (p % 4 == 2);
            out_idle_on = (p % 4 == 0) || (p % 4 == 3);
            if (p % 3 == 0)
                write_reg(CFG_UNMAPPED, 16'($urandom()));
            if (p == 0)
                set_levels(4'd1, 4'd1, 16'hFFFF);
            else if (p == 1)
                set_levels(4'd15, 4'd15, 16'd0);
            else
                set_levels(pick_shift(), pick_shift(), pick_scale());
            queue_wave(PHASE_ITEMS / 2);
            // hold the sender off until the pipeline is empty
            if (p % 4 == 1)
                drain_pipeline();
            queue_wave(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain_pipeline();
        end

        repeat (8) @(negedge clk);
        if (error_count == 0 && expected_levels.size() == 0)
            $display("dc_removed_envelope_peak_detector verification clean");
        else
            $display("dc_removed_envelope_peak_detector verification failed");
        $finish;
    end

endmodule
